[design/integer_list_fold_alu_assert.svh]
// Assertion macros for the integer list fold ALU.
// Included by integer_list_fold_alu.sv; expects clk and rst in scope.
`ifndef INTEGER_LIST_FOLD_ALU_ASSERT_SVH
`define INTEGER_LIST_FOLD_ALU_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked only outside reset
`define ILFA_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ilfa assertion failed");
// checked at every edge, reset included
`define ILFA_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("ilfa assertion failed");
`else
`define ILFA_ASSERT(name, prop)
`define ILFA_ASSERT_ALWAYS(name, prop)
`endif
`endif

[design/ilfa_pkg.sv]
// Package for the integer list fold ALU: state, opcode, status and
// register index types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ilfa_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_CHECK,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_QUO   = 3'd4,
    OP_FLOOR = 3'd5,
    OP_REM   = 3'd6,
    OP_MOD   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DIV_ZERO = 2'd1,
    STATUS_INEXACT  = 2'd2
  } status_t;

  typedef enum logic {
    REG_MIN_EXACT = 1'b0,
    REG_MAX_EXACT = 1'b1
  } reg_idx_t;

  localparam logic [31:0] MIN_EXACT_RESET = 32'h8000_0000;
  localparam logic [30:0] MAX_EXACT_RESET = 31'h7FFF_FFFF;
  localparam logic [31:0] UNIT_VALUE      = 32'd1;
  localparam logic [4:0]  STEP_LAST       = 5'd31;

endpackage

`default_nettype wire

[design/integer_list_fold_alu.sv]
// Integer list fold ALU: folds a stream of signed 32-bit words with one op.
// Uses ilfa_pkg and integer_list_fold_alu_assert.svh.
//
// Usage:
//  - Input channel (in_valid/in_ready): one word per list element with op,
//    value, first and last. first reloads the accumulator and clears status.
//  - Output channel (out_valid/out_ready): one word per element marked last,
//    carrying result and status (result reads 0 when status is not ok).
//  - APB port: min_exact at 0x0, max_exact at 0x4; write only while idle.
//  - Sequence: add, sub, loads and frozen lists go from the accept to CHECK,
//    then EMIT for a last word, and out_valid is registered from EMIT; mul and
//    divides by nonzero values first pass the shared radix-2 shift-add /
//    restoring-divide unit, one bit per cycle for 32 bits, then FIX and CHECK.
//  - Flow: one element at a time; in_ready is high only while the sequencer is idle.
//  - The output register holds a finished word, so a new element is taken
//    while the receiver stalls; the next last word waits for it to drain.
//  - Reset (synchronous): accumulator 0, status ok, range registers to
//    full int32, output channel empty.
`timescale 1ns / 1ps
`default_nettype none

module integer_list_fold_alu (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  op,
  input  wire logic [31:0] value,
  input  wire logic        first,
  input  wire logic        last,
  // output channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      result,
  output logic [1:0]       status,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  `include "integer_list_fold_alu_assert.svh"

  // config registers
  logic [31:0] min_exact;
  logic [30:0] max_exact;

  // fold state
  logic [31:0]             acc;
  ilfa_pkg::status_t       err;

  // sequencer
  ilfa_pkg::state_t state, state_next;
  logic [4:0]  cnt;

  // captured element
  ilfa_pkg::op_t     op_q;
  logic [31:0]       val_q;
  logic              last_q;
  logic              neg_q;

  // serial unit: hi = partial product / remainder, lo = multiplier / quotient
  logic [31:0] hi_r;
  logic [31:0] lo_r;
  logic [31:0] b_r;

  // candidate for the range check
  logic signed [63:0] cand;
  ilfa_pkg::status_t  cand_err;

  // dispatch decode at accept
  ilfa_pkg::state_t   disp_state;
  logic signed [33:0] disp_cand;
  ilfa_pkg::status_t  disp_err;
  logic signed [33:0] a34, v34;
  logic [31:0]        mag_val, mag_acc;

  // post-process
  logic signed [63:0] fix_cand;
  ilfa_pkg::status_t  fix_err;
  logic [63:0]        prod_mag;
  logic signed [33:0] q34, m34, c34, dv34;
  logic               m_nz;

  // serial step
  logic [32:0] mul_sum;
  logic [32:0] div_sh;
  logic [33:0] div_diff;

  // range check
  logic signed [63:0] lo64, hi64;
  logic               out_of_range;

  logic out_free;
  logic cfg_wr;

  // ---------------- config port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_exact <= ilfa_pkg::MIN_EXACT_RESET;
      max_exact <= ilfa_pkg::MAX_EXACT_RESET;
    end else if (cfg_wr) begin
      unique case (ilfa_pkg::reg_idx_t'(paddr[2]))
        ilfa_pkg::REG_MIN_EXACT: min_exact <= pwdata;
        ilfa_pkg::REG_MAX_EXACT: max_exact <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ilfa_pkg::reg_idx_t'(paddr[2]))
      ilfa_pkg::REG_MIN_EXACT: prdata = min_exact;
      ilfa_pkg::REG_MAX_EXACT: prdata = {1'b0, max_exact};
      default:                 prdata = 32'd0;
    endcase
  end

  // ---------------- dispatch ----------------
  // Loads, add, sub, frozen lists and divides by zero finish here; mul and other divides go to the serial unit.
  assign a34     = {{2{acc[31]}}, acc};
  assign v34     = {{2{value[31]}}, value};
  assign mag_val = value[31] ? (~value + 32'd1) : value;
  assign mag_acc = acc[31] ? (~acc + 32'd1) : acc;

  always_comb begin
    disp_state = ilfa_pkg::ST_CHECK;
    disp_cand  = v34;
    disp_err   = ilfa_pkg::STATUS_OK;
    if (first) begin
      if (last && ilfa_pkg::op_t'(op) == ilfa_pkg::OP_SUB) begin
        disp_cand = 34'sd0 - v34;
      end else if (last && ilfa_pkg::op_t'(op) == ilfa_pkg::OP_DIV) begin
        // single-element divide: only a value of one is exact
        if (value != ilfa_pkg::UNIT_VALUE) disp_err = ilfa_pkg::STATUS_INEXACT;
      end
    end else if (err != ilfa_pkg::STATUS_OK) begin
      disp_err = err;  // list frozen: keep status
    end else begin
      case (ilfa_pkg::op_t'(op))
        ilfa_pkg::OP_ADD: disp_cand = a34 + v34;
        ilfa_pkg::OP_SUB: disp_cand = a34 - v34;
        ilfa_pkg::OP_MUL: disp_state = ilfa_pkg::ST_MUL;
        ilfa_pkg::OP_DIV: begin
          if (value == 32'd0) disp_err = ilfa_pkg::STATUS_INEXACT;
          else                disp_state = ilfa_pkg::ST_DIV;
        end
        default: begin
          if (value == 32'd0) disp_err = ilfa_pkg::STATUS_DIV_ZERO;
          else                disp_state = ilfa_pkg::ST_DIV;
        end
      endcase
    end
  end

  // ---------------- serial step ----------------
  assign mul_sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, b_r} : 33'd0);
  assign div_sh   = {hi_r, lo_r[31]};
  assign div_diff = {1'b0, div_sh} - {2'b00, b_r};

  // ---------------- post-process ----------------
  // Signs come from the accumulator (unchanged while busy) and the divisor.
  assign prod_mag = {hi_r, lo_r};
  assign m_nz     = |hi_r;
  assign c34      = {{2{val_q[31]}}, val_q};
  assign q34      = neg_q ? (34'sd0 - $signed({2'b00, lo_r})) : $signed({2'b00, lo_r});
  assign m34      = acc[31] ? (34'sd0 - $signed({2'b00, hi_r})) : $signed({2'b00, hi_r});

  always_comb begin
    fix_err = ilfa_pkg::STATUS_OK;
    dv34    = q34;
    case (op_q)
      ilfa_pkg::OP_DIV: begin
        if (m_nz) fix_err = ilfa_pkg::STATUS_INEXACT;
      end
      ilfa_pkg::OP_FLOOR: begin
        if (m_nz && (val_q[31] != acc[31])) dv34 = q34 - 34'sd1;
      end
      ilfa_pkg::OP_REM: dv34 = m34;
      ilfa_pkg::OP_MOD: begin
        // nonzero remainder takes the divisor's sign
        if (m_nz && (acc[31] != val_q[31])) dv34 = m34 + c34;
        else                                dv34 = m34;
      end
      default: ;
    endcase
    if (op_q == ilfa_pkg::OP_MUL)
      fix_cand = neg_q ? $signed(~prod_mag + 64'd1) : $signed(prod_mag);
    else
      fix_cand = {{30{dv34[33]}}, dv34};
  end

  // ---------------- range check ----------------
  assign lo64         = {{32{min_exact[31]}}, min_exact};
  assign hi64         = {33'd0, max_exact};
  assign out_of_range = (cand < lo64) || (cand > hi64);

  // ---------------- sequencer ----------------
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= ilfa_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      ilfa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = disp_state;
      end
      ilfa_pkg::ST_MUL,
      ilfa_pkg::ST_DIV: begin
        if (cnt == 5'd0) state_next = ilfa_pkg::ST_FIX;
      end
      ilfa_pkg::ST_FIX:   state_next = ilfa_pkg::ST_CHECK;
      ilfa_pkg::ST_CHECK: state_next = last_q ? ilfa_pkg::ST_EMIT : ilfa_pkg::ST_IDLE;
      ilfa_pkg::ST_EMIT: begin
        if (out_free) state_next = ilfa_pkg::ST_IDLE;
      end
      default: state_next = ilfa_pkg::ST_IDLE;
    endcase
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    unique case (state)
      ilfa_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_q     <= ilfa_pkg::op_t'(op);
          val_q    <= value;
          last_q   <= last;
          neg_q    <= acc[31] ^ value[31];
          cand     <= {{30{disp_cand[33]}}, disp_cand};
          cand_err <= disp_err;
          cnt      <= ilfa_pkg::STEP_LAST;
          hi_r     <= 32'd0;
          if (disp_state == ilfa_pkg::ST_MUL) begin
            lo_r <= mag_val;
            b_r  <= mag_acc;
          end else begin
            lo_r <= mag_acc;
            b_r  <= mag_val;
          end
        end
      end
      ilfa_pkg::ST_MUL: begin
        hi_r <= mul_sum[32:1];
        lo_r <= {mul_sum[0], lo_r[31:1]};
        cnt  <= cnt - 5'd1;
      end
      ilfa_pkg::ST_DIV: begin
        if (!div_diff[33]) begin
          hi_r <= div_diff[31:0];
          lo_r <= {lo_r[30:0], 1'b1};
        end else begin
          hi_r <= div_sh[31:0];
          lo_r <= {lo_r[30:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
      end
      ilfa_pkg::ST_FIX: begin
        cand     <= fix_cand;
        cand_err <= fix_err;
      end
      default: ;
    endcase
  end

  // commit into the accumulator or latch the error
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 32'd0;
      err <= ilfa_pkg::STATUS_OK;
    end else if (state == ilfa_pkg::ST_CHECK) begin
      if (cand_err != ilfa_pkg::STATUS_OK) begin
        err <= cand_err;
      end else if (out_of_range) begin
        err <= ilfa_pkg::STATUS_INEXACT;
      end else begin
        acc <= cand[31:0];
        err <= ilfa_pkg::STATUS_OK;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ilfa_pkg::ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ilfa_pkg::ST_EMIT && out_free) begin
      result <= (err != ilfa_pkg::STATUS_OK) ? 32'd0 : acc;
      status <= err;
    end
  end

  // ---------------- assertions ----------------
  `ILFA_ASSERT(a_err_zero_result, out_valid && (status != ilfa_pkg::STATUS_OK) |-> result == 32'd0)
  `ILFA_ASSERT(a_serial_done, (state == ilfa_pkg::ST_MUL || state == ilfa_pkg::ST_DIV) && cnt == 5'd0 |=> state == ilfa_pkg::ST_FIX)
  `ILFA_ASSERT(a_acc_hold, (state == ilfa_pkg::ST_MUL || state == ilfa_pkg::ST_DIV) |=> $stable(acc))
  `ILFA_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid && state == ilfa_pkg::ST_IDLE)

endmodule

`default_nettype wire

[tb/sv/fold_result_checker.sv]
`timescale 1ns / 1ps
// Result checker for integer_list_fold_alu: follows the range registers and
// the input words, predicts each list result, and compares the output words.
// Uses ilfa_pkg for op, status and register index types.

module fold_result_checker
  import ilfa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [2:0]  op,
  input  wire logic [31:0] value,
  input  wire logic        first,
  input  wire logic        last,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] result,
  input  wire logic [1:0]  status,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               fail_count,
  output int               pending_words
);

  typedef struct packed {
    logic [31:0] result;
    status_t     status;
  } fold_word_t;

  fold_word_t         expected_words[$];
  logic [31:0]        min_exact_cfg;
  logic [30:0]        max_exact_cfg;
  logic signed [31:0] acc;
  status_t            list_status;

  // store v when inside [min_exact, max_exact], else flag inexact
  task automatic settle(longint v);
    longint lo;
    longint hi;
    lo = longint'($signed(min_exact_cfg));
    hi = longint'({1'b0, max_exact_cfg});
    if (v < lo || v > hi) begin
      list_status = STATUS_INEXACT;
    end else begin
      acc = v[31:0];
    end
  endtask

  task automatic fold_word(op_t o, longint c);
    longint r;
    longint q;
    longint m;
    r = acc;
    case (o)
      OP_ADD: settle(r + c);
      OP_SUB: settle(r - c);
      OP_MUL: settle(r * c);
      OP_DIV: begin
        if (c == 0) begin
          list_status = STATUS_INEXACT;
        end else if (r % c != 0) begin
          list_status = STATUS_INEXACT;
        end else begin
          settle(r / c);
        end
      end
      default: begin
        if (c == 0) begin
          list_status = STATUS_DIV_ZERO;
        end else begin
          q = r / c;
          m = r % c;
          case (o)
            OP_QUO: settle(q);
            OP_FLOOR: begin
              if (m != 0 && ((c < 0) != (r < 0))) q = q - 1;
              settle(q);
            end
            OP_REM: settle(m);
            default: begin
              // modulo: remainder takes the divisor's sign
              if (m != 0 && ((m < 0) != (c < 0))) m = m + c;
              settle(m);
            end
          endcase
        end
      end
    endcase
  endtask

  task automatic take_word(op_t o, logic [31:0] v, logic f, logic l);
    longint     c;
    fold_word_t w;
    c = longint'($signed(v));
    if (f) begin
      list_status = STATUS_OK;
      if (l && o == OP_SUB) begin
        settle(-c);
      end else if (l && o == OP_DIV) begin
        if (c == 1) settle(c);
        else list_status = STATUS_INEXACT;
      end else begin
        settle(c);
      end
    end else if (list_status == STATUS_OK) begin
      fold_word(o, c);
    end
    if (l) begin
      w.result = (list_status == STATUS_OK) ? acc : '0;
      w.status = list_status;
      expected_words.push_back(w);
    end
  endtask

  task automatic check_word();
    fold_word_t w;
    if (expected_words.size() == 0) begin
      $error("unexpected output word: result %0d status %0d", $signed(result), status);
      fail_count++;
    end else begin
      w = expected_words.pop_front();
      if (result !== w.result) begin
        $error("result: expected %0d, actual %0d", $signed(w.result), $signed(result));
        fail_count++;
      end
      if (status !== w.status) begin
        $error("status: expected %0d, actual %0d", w.status, status);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_words.delete();
      min_exact_cfg = MIN_EXACT_RESET;
      max_exact_cfg = MAX_EXACT_RESET;
      acc           = '0;
      list_status   = STATUS_OK;
      fail_count    = 0;
    end else begin
      // compare first: a word taken at this edge cannot be answered at it
      if (out_valid && out_ready) check_word();
      if (in_valid && in_ready) take_word(op_t'(op), value, first, last);
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[2]))
          REG_MIN_EXACT: min_exact_cfg = pwdata;
          REG_MAX_EXACT: max_exact_cfg = pwdata[30:0];
        endcase
      end
    end
    pending_words = expected_words.size();
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Top of the integer_list_fold_alu testbench: clock, reset, list stimulus,
// output stalls, range register writes and the verdict. Uses ilfa_pkg and
// fold_result_checker, which does all prediction and comparison.

module tb;
  import ilfa_pkg::*;

  localparam int QUIET_LIMIT = 3000;  // cycles with no handshake at all
  localparam int LONG_HOLD   = 400;   // receiver hold-off, fills the block
  localparam int SETTLE_GAP  = 50;    // outlasts a mul/div word

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  op = '0;
  logic [31:0] value = '0;
  logic        first = 1'b0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] result;
  logic [1:0]  status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending_words;
  int quiet_cycles = 0;
  int sent_words = 0;
  int idle_pct = 0;     // sender gap odds, percent per cycle
  int stall_pct = 0;    // receiver stall odds, percent per cycle
  int hold_left = 0;
  bit hold_req = 1'b0;

  always #5 clk = ~clk;

  integer_list_fold_alu u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .value    (value),
    .first    (first),
    .last     (last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result   (result),
    .status   (status),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  fold_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .value        (value),
    .first        (first),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result       (result),
    .status       (status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .pending_words(pending_words)
  );

  // Watchdog: any handshake on either channel or the APB port restarts it.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls per phase, plus one long hold-off on request.
  // The hold is counted here so the sender keeps offering words meanwhile.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  // valid is only raised here and dropped in gaps, never both in one step.
  task automatic send_word(op_t o, logic [31:0] v, logic f, logic l);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    value    <= v;
    first    <= f;
    last     <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_words++;
    @(negedge clk);
  endtask

  // Returns at the falling edge after the port is released, so a following
  // write starts its setup phase in a fresh step.
  task automatic write_range_reg(reg_idx_t idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Quiesce: stop sending, wait for every expected word, then let a word
  // that makes no result (mid-list mul/div) finish before touching a register.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (SETTLE_GAP) @(negedge clk);
  endtask

  task automatic set_range(logic [31:0] lo, logic [31:0] hi);
    drain_block();
    write_range_reg(REG_MIN_EXACT, lo);
    write_range_reg(REG_MAX_EXACT, hi);
  endtask

  function automatic logic [31:0] any_value();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      5, 6:    return $urandom_range(200) - 100;
      7:       return ($urandom_range(1) ? 32'd0 : 32'hFFFF_0000) ^ $urandom_range(65535);
      default: return $urandom();
    endcase
  endfunction

  // mostly small nonzero factors so mul/div lists stay exact for a while
  function automatic logic [31:0] small_factor();
    logic [31:0] f;
    if ($urandom_range(15) == 0) return 32'd0;
    f = $urandom_range(1, 9);
    return $urandom_range(1) ? -f : f;
  endfunction

  // One list, usually well formed with one op. Exact-divide lists start from
  // a product of the later divisors; a few lists lose their first or last
  // mark, carry a stray op, or are single noise words.
  task automatic send_random_list();
    op_t         lop;
    op_t         eop;
    int          len;
    int          kind;
    logic [31:0] fac[5];
    logic [31:0] head;
    logic        f;
    logic        l;
    logic [31:0] v;
    lop  = op_t'($urandom_range(7));
    len  = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 5);
    kind = $urandom_range(99);
    if (kind < 8) begin
      send_word(op_t'($urandom_range(7)), any_value(), 1'($urandom_range(1)),
                1'($urandom_range(1)));
    end else begin
      foreach (fac[i]) fac[i] = small_factor();
      if (lop == OP_DIV) begin
        head = small_factor();
        for (int i = 1; i < len; i++) head = head * fac[i];
        if ($urandom_range(7) == 0) head = head + 1;
      end else begin
        head = any_value();
      end
      for (int i = 0; i < len; i++) begin
        f = (i == 0) && !(kind < 12);
        l = (i == len - 1) && !(kind >= 12 && kind < 16);
        if (i == 0) v = head;
        else if (lop == OP_DIV || lop == OP_MUL) v = fac[i];
        else v = any_value();
        eop = ($urandom_range(29) == 0) ? op_t'($urandom_range(7)) : lop;
        send_word(eop, v, f, l);
      end
    end
  endtask

  task automatic run_phase(int words, int send_idle, int recv_stall);
    int target;
    target    = sent_words + words;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    while (sent_words < target) send_random_list();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words, reset range (full int32), no idling.
    send_word(OP_ADD, 32'd5, 1'b0, 1'b1);              // no first mark after reset: 0 + 5
    send_word(OP_ADD, 32'h7FFF_FFFF, 1'b1, 1'b1);
    send_word(OP_SUB, 32'd5, 1'b1, 1'b1);              // lone sub negates
    send_word(OP_SUB, 32'h8000_0000, 1'b1, 1'b1);      // -(-2^31) out of range
    send_word(OP_MUL, 32'hFFFF_FFFD, 1'b1, 1'b1);
    send_word(OP_DIV, 32'd1, 1'b1, 1'b1);              // lone divide keeps 1
    send_word(OP_DIV, 32'd5, 1'b1, 1'b1);              // any other lone value is inexact
    send_word(OP_QUO, 32'd0, 1'b1, 1'b1);
    send_word(OP_FLOOR, 32'hFFFF_FFF7, 1'b1, 1'b1);
    send_word(OP_REM, 32'd12, 1'b1, 1'b1);
    send_word(OP_MOD, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_word(OP_QUO, 32'h8000_0000, 1'b1, 1'b0);      // -2^31 / -1 overflows
    send_word(OP_QUO, 32'hFFFF_FFFF, 1'b0, 1'b1);
    send_word(OP_QUO, 32'd17, 1'b1, 1'b0);             // integer divide by zero
    send_word(OP_QUO, 32'd0, 1'b0, 1'b1);
    send_word(OP_DIV, 32'd17, 1'b1, 1'b0);             // exact divide by zero is inexact
    send_word(OP_DIV, 32'd0, 1'b0, 1'b0);
    send_word(OP_ADD, 32'd3, 1'b0, 1'b1);              // list frozen after the error
    send_word(OP_MOD, 32'hFFFF_FFF9, 1'b1, 1'b0);      // -7 mod 2 = 1
    send_word(OP_MOD, 32'd2, 1'b0, 1'b1);
    send_word(OP_MOD, 32'd6, 1'b1, 1'b0);              // zero remainder, no divisor added
    send_word(OP_MOD, 32'hFFFF_FFFD, 1'b0, 1'b1);
    send_word(OP_FLOOR, 32'hFFFF_FFF9, 1'b1, 1'b0);    // floor(-7 / 2) = -4
    send_word(OP_FLOOR, 32'd2, 1'b0, 1'b1);
    send_word(OP_ADD, 32'h7FFF_FFFF, 1'b1, 1'b0);      // sum checked before it wraps
    send_word(OP_ADD, 32'd1, 1'b0, 1'b1);
    send_word(OP_DIV, 32'd12, 1'b1, 1'b0);
    send_word(OP_DIV, 32'd4, 1'b0, 1'b0);
    send_word(OP_DIV, 32'd3, 1'b0, 1'b1);

    run_phase(300, 0, 0);
    set_range(-32'sd1000, 32'd1000);
    run_phase(350, 45, 0);
    set_range(32'd0, 32'd0);                           // only zero is exact
    run_phase(200, 0, 45);
    set_range(32'h8000_0000, 32'hFFFF_FFFF);           // top bit of max_exact is dropped
    run_phase(350, 32, 32);
    set_range(32'h8000_0000, 32'd0);
    hold_req = 1'b1;                                   // block fills while sender pushes
    run_phase(200, 0, 0);
    set_range(32'd0, 32'h7FFF_FFFF);
    run_phase(350, 32, 32);

    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
